FILE: hw/rtl/lee_pkg.sv
// ----------------------------------------------------------------------------
// lee_pkg
// Shared types, register map and reset constants of the lamp effect engine.
// ----------------------------------------------------------------------------
package lee_pkg;

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_COLOR_A     = 3'd1;
  localparam logic [2:0] REG_COLOR_B     = 3'd2;
  localparam logic [2:0] REG_COLOR_C     = 3'd3;
  localparam logic [2:0] REG_BRIGHT_PCT  = 3'd4;
  localparam logic [2:0] REG_HOLD_TICKS  = 3'd5;
  localparam logic [2:0] REG_FADE_TICKS  = 3'd6;
  localparam logic [2:0] REG_RAINBOW_DIV = 3'd7;

  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_STATIC  = 2'd1;
  localparam logic [1:0] MODE_FADE    = 2'd2;
  localparam logic [1:0] MODE_RAINBOW = 2'd3;

  localparam logic [1:0]  MODE_RST        = MODE_RAINBOW;
  localparam logic [23:0] COLOR_A_RST     = 24'hB4E61D;
  localparam logic [23:0] COLOR_B_RST     = 24'h000000;
  localparam logic [23:0] COLOR_C_RST     = 24'h000000;
  localparam logic [7:0]  BRIGHT_PCT_RST  = 8'd20;
  localparam logic [15:0] HOLD_TICKS_RST  = 16'd400;
  localparam logic [15:0] FADE_TICKS_RST  = 16'd200;
  localparam logic [15:0] RAINBOW_DIV_RST = 16'd3;

  localparam logic [7:0] RAMP_RED_RST   = 8'd180;
  localparam logic [7:0] RAMP_GREEN_RST = 8'd230;
  localparam logic [7:0] RAMP_BLUE_RST  = 8'd29;

  localparam logic [1:0] CHAN_RED   = 2'd0;
  localparam logic [1:0] CHAN_GREEN = 2'd1;
  localparam logic [1:0] CHAN_BLUE  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] color_a;
    logic [23:0] color_b;
    logic [23:0] color_c;
    logic [7:0]  bright_pct;
    logic [15:0] hold_ticks;
    logic [15:0] fade_ticks;
    logic [15:0] rainbow_div;
  } lee_cfg_t;

  typedef struct packed {
    logic       take;
    logic       update;
    logic       scale_start;
    logic [1:0] chan;
  } lee_cmd_t;

  typedef struct packed {
    logic show;
    logic scale_done;
  } lee_sts_t;

endpackage

FILE: hw/rtl/lee_tick_if.sv
// ----------------------------------------------------------------------------
// lee_tick_if
// Tick channel: valid/ready handshake with the restart flag as payload.
// ----------------------------------------------------------------------------
interface lee_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

FILE: hw/rtl/lee_duty_if.sv
// ----------------------------------------------------------------------------
// lee_duty_if
// Duty channel: valid/ready handshake carrying the three PWM duties.
// ----------------------------------------------------------------------------
interface lee_duty_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_duty;
  logic [7:0] green_duty;
  logic [7:0] blue_duty;

  modport source (output valid, output red_duty, output green_duty, output blue_duty,
                  input ready);
  modport sink (input valid, input red_duty, input green_duty, input blue_duty,
                output ready);
endinterface

FILE: hw/rtl/lee_regs.sv
// ----------------------------------------------------------------------------
// lee_regs
// APB register file holding the effect configuration.
// ----------------------------------------------------------------------------
module lee_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lee_pkg::APB_AW-1:0] paddr,
  input  logic [lee_pkg::APB_DW-1:0] pwdata,
  output logic [lee_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output lee_pkg::lee_cfg_t          cfg
);
  import lee_pkg::*;

  logic [2:0] index;
  logic       wr;

  assign index  = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode        <= MODE_RST;
      cfg.color_a     <= COLOR_A_RST;
      cfg.color_b     <= COLOR_B_RST;
      cfg.color_c     <= COLOR_C_RST;
      cfg.bright_pct  <= BRIGHT_PCT_RST;
      cfg.hold_ticks  <= HOLD_TICKS_RST;
      cfg.fade_ticks  <= FADE_TICKS_RST;
      cfg.rainbow_div <= RAINBOW_DIV_RST;
    end else if (wr) begin
      unique case (index)
        REG_MODE:        cfg.mode        <= pwdata[1:0];
        REG_COLOR_A:     cfg.color_a     <= pwdata[23:0];
        REG_COLOR_B:     cfg.color_b     <= pwdata[23:0];
        REG_COLOR_C:     cfg.color_c     <= pwdata[23:0];
        REG_BRIGHT_PCT:  cfg.bright_pct  <= pwdata[7:0];
        REG_HOLD_TICKS:  cfg.hold_ticks  <= pwdata[15:0];
        REG_FADE_TICKS:  cfg.fade_ticks  <= pwdata[15:0];
        REG_RAINBOW_DIV: cfg.rainbow_div <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_MODE:        prdata = {30'b0, cfg.mode};
      REG_COLOR_A:     prdata = {8'b0, cfg.color_a};
      REG_COLOR_B:     prdata = {8'b0, cfg.color_b};
      REG_COLOR_C:     prdata = {8'b0, cfg.color_c};
      REG_BRIGHT_PCT:  prdata = {24'b0, cfg.bright_pct};
      REG_HOLD_TICKS:  prdata = {16'b0, cfg.hold_ticks};
      REG_FADE_TICKS:  prdata = {16'b0, cfg.fade_ticks};
      REG_RAINBOW_DIV: prdata = {16'b0, cfg.rainbow_div};
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/lee_scale.sv
// ----------------------------------------------------------------------------
// lee_scale
// Multi-cycle brightness scaler: color*pct*level/(100*ticks), saturated at 255.
// Multiply steps, a saturation check, then an 8-step restoring divide.
// ----------------------------------------------------------------------------
module lee_scale (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [7:0]  color,
  input  logic [7:0]  pct,
  input  logic [15:0] level,
  input  logic [15:0] ticks,
  output logic        done,
  output logic [7:0]  duty
);
  import lee_pkg::*;

  localparam logic [1:0] SC_IDLE = 2'd0;
  localparam logic [1:0] SC_MUL  = 2'd1;
  localparam logic [1:0] SC_CHK  = 2'd2;
  localparam logic [1:0] SC_DIV  = 2'd3;

  localparam logic [6:0] PCT_FULL = 7'd100;

  logic [1:0]  state;
  logic [15:0] prod;
  logic [15:0] lvl;
  logic [22:0] den;
  logic [31:0] num;
  logic [30:0] dsh;
  logic [2:0]  cnt;
  logic [15:0] fden;
  logic        ge;

  assign fden = (ticks == 16'd0) ? 16'd1 : ticks;
  assign ge   = num >= {1'b0, dsh};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        SC_IDLE: begin
          if (start) begin
            state <= SC_MUL;
          end
        end
        SC_MUL: begin
          state <= SC_CHK;
        end
        SC_CHK: begin
          if (num >= {1'b0, den, 8'b0}) begin
            state <= SC_IDLE;
            done  <= 1'b1;
          end else begin
            state <= SC_DIV;
          end
        end
        SC_DIV: begin
          if (cnt == 3'd0) begin
            state <= SC_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= SC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      SC_IDLE: begin
        if (start) begin
          prod <= {8'b0, color} * {8'b0, pct};
          lvl  <= (ticks == 16'd0) ? 16'd1 : level;
          den  <= {16'b0, PCT_FULL} * {7'b0, fden};
        end
      end
      SC_MUL: begin
        num <= {16'b0, prod} * {16'b0, lvl};
      end
      SC_CHK: begin
        if (num >= {1'b0, den, 8'b0}) begin
          duty <= 8'hFF;
        end else begin
          duty <= 8'h00;
          dsh  <= {1'b0, den, 7'b0};
          cnt  <= 3'd7;
        end
      end
      SC_DIV: begin
        if (ge) begin
          num <= num - {1'b0, dsh};
        end
        duty <= {duty[6:0], ge};
        dsh  <= {1'b0, dsh[30:1]};
        cnt  <= cnt - 3'd1;
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/lee_dp.sv
// ----------------------------------------------------------------------------
// lee_dp
// Effect datapath: ramps, fade cycle counters, prescaler and duty register.
// ----------------------------------------------------------------------------
module lee_dp (
  input  logic              clk,
  input  logic              rst,
  input  lee_pkg::lee_cfg_t cfg,
  input  lee_pkg::lee_cmd_t cmd,
  output lee_pkg::lee_sts_t sts,
  input  logic              restart,
  output logic [7:0]        red_duty,
  output logic [7:0]        green_duty,
  output logic [7:0]        blue_duty
);
  import lee_pkg::*;

  function automatic logic [8:0] bounce(input logic [7:0] val, input logic [1:0] step,
                                        input logic up);
    logic [8:0] sum;
    logic [7:0] res;
    logic       rise;
    sum = {1'b0, val} + {7'b0, step};
    if (up) begin
      if (sum >= 9'd255) begin
        res  = 8'hFF;
        rise = 1'b0;
      end else begin
        res  = sum[7:0];
        rise = 1'b1;
      end
    end else begin
      if (val <= {6'b0, step}) begin
        res  = 8'h00;
        rise = 1'b1;
      end else begin
        res  = val - {6'b0, step};
        rise = 1'b0;
      end
    end
    return {rise, res};
  endfunction

  logic        restart_q;
  logic [7:0]  ramp_red, ramp_green, ramp_blue;
  logic [2:0]  ramp_rising;
  logic [17:0] cycle_count;
  logic [1:0]  color_slot;
  logic        slot_advanced;
  logic [15:0] fade_level;
  logic [15:0] prescale_count;
  logic [23:0] duty_out;

  logic [7:0]  ramp_red_next, ramp_green_next, ramp_blue_next;
  logic [2:0]  ramp_rising_next;
  logic [17:0] cycle_count_next;
  logic [1:0]  color_slot_next;
  logic        slot_advanced_next;
  logic [15:0] fade_level_next;
  logic [15:0] prescale_count_next;

  logic        load_a;
  logic [15:0] fl0;
  logic [7:0]  r0, g0, b0;
  logic [2:0]  rise0;
  logic [17:0] cnt1, h18, f18, hf, hff;
  logic        step;
  logic [15:0] pre_base;
  logic [23:0] slot_color;
  logic [8:0]  br, bg, bb;
  logic        show;

  logic [7:0]  sc_color;
  logic        sc_done;
  logic [7:0]  sc_duty;

  always_comb begin
    load_a = restart_q && (cfg.mode == MODE_STATIC || cfg.mode == MODE_RAINBOW);
    fl0    = restart_q ? cfg.fade_ticks : fade_level;
    r0     = load_a ? cfg.color_a[23:16] : ramp_red;
    g0     = load_a ? cfg.color_a[15:8]  : ramp_green;
    b0     = load_a ? cfg.color_a[7:0]   : ramp_blue;
    rise0  = load_a ? 3'b000 : ramp_rising;

    cnt1 = cycle_count + 18'd1;
    h18  = {2'b0, cfg.hold_ticks};
    f18  = {2'b0, cfg.fade_ticks};
    hf   = h18 + f18;
    hff  = hf + f18;
    step = prescale_count >= cfg.rainbow_div;

    br = bounce(r0, 2'd1, rise0[0]);
    bg = bounce(g0, 2'd2, rise0[1]);
    bb = bounce(b0, 2'd3, rise0[2]);

    ramp_red_next       = r0;
    ramp_green_next     = g0;
    ramp_blue_next      = b0;
    ramp_rising_next    = rise0;
    cycle_count_next    = cycle_count;
    color_slot_next     = color_slot;
    slot_advanced_next  = slot_advanced;
    fade_level_next     = fl0;
    pre_base            = prescale_count;
    slot_color          = cfg.color_a;
    show                = 1'b0;

    unique case (cfg.mode)
      MODE_STATIC: begin
        show = 1'b1;
      end
      MODE_FADE: begin
        show             = 1'b1;
        cycle_count_next = cnt1;
        if (cnt1 >= h18 && cnt1 < hf) begin
          fade_level_next = (fl0 != 16'd0) ? fl0 - 16'd1 : fl0;
        end
        if (cnt1 >= hf && cnt1 < hff) begin
          if (!slot_advanced) begin
            color_slot_next    = (color_slot >= CHAN_BLUE) ? CHAN_RED : color_slot + 2'd1;
            slot_advanced_next = 1'b1;
          end
          fade_level_next = (fl0 < cfg.fade_ticks) ? fl0 + 16'd1 : cfg.fade_ticks;
        end
        if (cnt1 > hff) begin
          fade_level_next    = cfg.fade_ticks;
          cycle_count_next   = 18'd0;
          slot_advanced_next = 1'b0;
        end
        case (color_slot_next)
          2'd0:    slot_color = cfg.color_a;
          2'd1:    slot_color = cfg.color_b;
          default: slot_color = cfg.color_c;
        endcase
        ramp_red_next   = slot_color[23:16];
        ramp_green_next = slot_color[15:8];
        ramp_blue_next  = slot_color[7:0];
      end
      MODE_RAINBOW: begin
        if (step) begin
          show             = 1'b1;
          pre_base         = 16'd0;
          ramp_red_next    = br[7:0];
          ramp_green_next  = bg[7:0];
          ramp_blue_next   = bb[7:0];
          ramp_rising_next = {bb[8], bg[8], br[8]};
        end
      end
      default: ;
    endcase

    prescale_count_next = (pre_base == 16'hFFFF) ? pre_base : pre_base + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      restart_q <= restart;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_red       <= RAMP_RED_RST;
      ramp_green     <= RAMP_GREEN_RST;
      ramp_blue      <= RAMP_BLUE_RST;
      ramp_rising    <= 3'b000;
      cycle_count    <= 18'd0;
      color_slot     <= 2'd0;
      slot_advanced  <= 1'b0;
      fade_level     <= FADE_TICKS_RST;
      prescale_count <= 16'd0;
      duty_out       <= 24'd0;
    end else begin
      if (cmd.update) begin
        ramp_red       <= ramp_red_next;
        ramp_green     <= ramp_green_next;
        ramp_blue      <= ramp_blue_next;
        ramp_rising    <= ramp_rising_next;
        cycle_count    <= cycle_count_next;
        color_slot     <= color_slot_next;
        slot_advanced  <= slot_advanced_next;
        fade_level     <= fade_level_next;
        prescale_count <= prescale_count_next;
      end
      if (sc_done) begin
        case (cmd.chan)
          CHAN_RED:   duty_out[23:16] <= sc_duty;
          CHAN_GREEN: duty_out[15:8]  <= sc_duty;
          default:    duty_out[7:0]   <= sc_duty;
        endcase
      end
    end
  end

  always_comb begin
    case (cmd.chan)
      CHAN_RED:   sc_color = ramp_red;
      CHAN_GREEN: sc_color = ramp_green;
      default:    sc_color = ramp_blue;
    endcase
  end

  lee_scale u_scale (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.scale_start),
    .color (sc_color),
    .pct   (cfg.bright_pct),
    .level (fade_level),
    .ticks (cfg.fade_ticks),
    .done  (sc_done),
    .duty  (sc_duty)
  );

  assign sts.show       = show;
  assign sts.scale_done = sc_done;

  assign red_duty   = duty_out[23:16];
  assign green_duty = duty_out[15:8];
  assign blue_duty  = duty_out[7:0];

endmodule

FILE: hw/rtl/lee_ctrl.sv
// ----------------------------------------------------------------------------
// lee_ctrl
// Tick sequencer: accept, update state, scale three channels if shown, present duties.
// ----------------------------------------------------------------------------
module lee_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lee_pkg::lee_cmd_t cmd,
  input  lee_pkg::lee_sts_t sts
);
  import lee_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UPDATE = 3'd1;
  localparam logic [2:0] ST_START  = 3'd2;
  localparam logic [2:0] ST_WAIT   = 3'd3;
  localparam logic [2:0] ST_OUTPUT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] chan;
  logic [1:0] chan_next;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUTPUT);

  always_comb begin
    state_next      = state;
    chan_next       = chan;
    cmd.take        = 1'b0;
    cmd.update      = 1'b0;
    cmd.scale_start = 1'b0;
    cmd.chan        = chan;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        chan_next  = CHAN_RED;
        state_next = sts.show ? ST_START : ST_OUTPUT;
      end
      ST_START: begin
        cmd.scale_start = 1'b1;
        state_next      = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.scale_done) begin
          if (chan == CHAN_BLUE) begin
            state_next = ST_OUTPUT;
          end else begin
            chan_next  = chan + 2'd1;
            state_next = ST_START;
          end
        end
      end
      ST_OUTPUT: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      chan  <= CHAN_RED;
    end else begin
      state <= state_next;
      chan  <= chan_next;
    end
  end

endmodule

FILE: hw/rtl/rgb_lamp_effect_engine.sv
// ----------------------------------------------------------------------------
// rgb_lamp_effect_engine
// Lamp effect engine producing three PWM duties per tick.
// ----------------------------------------------------------------------------
// Usage:
//   tick: one transfer per effect tick (about 100 Hz); restart reloads the
//         ramps from color_a in static/rainbow and sets full brightness first.
//   duty: one transfer per tick carrying red, green and blue duties; duties
//         hold their last value when the tick does not refresh them.
//   APB:  eight configuration registers at byte address 4*i, written while
//         no tick is in flight.
// Sequence: without a refresh, duty goes valid right after the update state;
//   with one, each channel in turn goes through one shared scaler: multiply
//   steps, a saturation check and an 8-step restoring divide that is skipped
//   when the result saturates.
// Flow: one tick at a time; the next tick can be taken in the cycle after the
//   duty transfer. While duty is stalled the result and tick side both hold.
// Reset: registers return to their defaults, ramps to 180/230/29, duties to 0.
// ----------------------------------------------------------------------------
module rgb_lamp_effect_engine (
  input  logic                       clk,
  input  logic                       rst,
  lee_tick_if.sink                   tick,
  lee_duty_if.source                 duty,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lee_pkg::APB_AW-1:0] paddr,
  input  logic [lee_pkg::APB_DW-1:0] pwdata,
  output logic [lee_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import lee_pkg::*;

  lee_cfg_t cfg;
  lee_cmd_t cmd;
  lee_sts_t sts;

  lee_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lee_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .out_valid (duty.valid),
    .out_ready (duty.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  lee_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .restart    (tick.restart),
    .red_duty   (duty.red_duty),
    .green_duty (duty.green_duty),
    .blue_duty  (duty.blue_duty)
  );

endmodule

FILE: hw/rtl/lee_chk.sv
// ----------------------------------------------------------------------------
// lee_chk
// Port-level checker for the lamp effect engine, bound to the top level.
// ----------------------------------------------------------------------------
module lee_chk (
  input logic       clk,
  input logic       rst,
  input logic       tick_valid,
  input logic       tick_ready,
  input logic       duty_valid,
  input logic       duty_ready,
  input logic [7:0] red_duty,
  input logic [7:0] green_duty,
  input logic [7:0] blue_duty,
  input logic       pready
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(tick_ready && duty_valid))
    else $error("tick taken while a result is pending");

  a_no_same_cycle_result: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && tick_ready) |=> !duty_valid)
    else $error("result presented right after tick transfer");

  a_ready_after_result: assert property (@(posedge clk) disable iff (rst)
    (duty_valid && duty_ready) |=> tick_ready)
    else $error("tick side not reopened after result transfer");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (duty_valid && !duty_ready) |=>
      (duty_valid && $stable(red_duty) && $stable(green_duty) && $stable(blue_duty)))
    else $error("stalled result changed");

  a_pready_high: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind rgb_lamp_effect_engine lee_chk u_lee_chk (
  .clk        (clk),
  .rst        (rst),
  .tick_valid (tick.valid),
  .tick_ready (tick.ready),
  .duty_valid (duty.valid),
  .duty_ready (duty.ready),
  .red_duty   (duty.red_duty),
  .green_duty (duty.green_duty),
  .blue_duty  (duty.blue_duty),
  .pready     (pready)
);
